>>> rtl/core/sbwd_pkg.sv
// shared constants and types for the sierra lite black/white ditherer
package sbwd_pkg;

    localparam int LINE_WIDTH_W   = 11;
    localparam int GREY_W         = 8;
    localparam int ERR_W          = 8;
    localparam int HALF_W         = 9;
    localparam int QUARTER_W      = 7;
    localparam int SUM_W          = 11;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int LINE_WIDTH_RST = 1024;
    localparam int WHITE_THRESH   = 128;
    localparam int WHITE_LEVEL    = 255;

    typedef struct packed {
        logic                        white;
        logic signed [HALF_W-1:0]    half;
        logic signed [QUARTER_W-1:0] quarter;
    } quant_t;

endpackage

>>> rtl/core/sbwd_quant.sv
// threshold of one pixel plus its incoming error, and the error split
module sbwd_quant
    import sbwd_pkg::*;
(
    input  logic [GREY_W-1:0]        grey_level,
    input  logic signed [ERR_W-1:0]  below_err,
    input  logic signed [HALF_W-1:0] right_err,
    output quant_t                   result
);

    logic signed [SUM_W-1:0] pix;
    logic signed [SUM_W-1:0] pix_err;
    logic signed [SUM_W-1:0] half_full;
    logic signed [SUM_W-1:0] quarter_full;
    logic                    white;

    always_comb begin
        pix = SUM_W'(below_err) + SUM_W'(right_err)
            + $signed({{(SUM_W-GREY_W){1'b0}}, grey_level});
        white = (pix >= $signed(SUM_W'(WHITE_THRESH)));
        pix_err = white ? (pix - $signed(SUM_W'(WHITE_LEVEL))) : pix;
        // arithmetic shifts give floor division
        half_full = pix_err >>> 1;
        quarter_full = half_full >>> 1;
        result.white = white;
        result.half = half_full[HALF_W-1:0];
        result.quarter = quarter_full[QUARTER_W-1:0];
    end

endmodule

>>> rtl/core/sbwd_line_store.sv
// error line store: one write and one registered read per cycle, with write bypass
module sbwd_line_store
    import sbwd_pkg::*;
#(
    parameter int DEPTH = MAX_WIDTH_DEF
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [ERR_W-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [ERR_W-1:0]         wr_data
);

    logic [ERR_W-1:0] mem [DEPTH];
    logic [ERR_W-1:0] rd_data_reg;
    logic [ERR_W-1:0] byp_data_reg;
    logic             byp_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
            // a write to the same entry at the read edge wins
            byp_reg <= wr_en && (wr_addr == rd_addr);
            byp_data_reg <= wr_data;
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : rd_data_reg;

endmodule

>>> rtl/core/sierra_lite_bw_dither.sv
// sierra lite error diffusion ditherer, 8-bit grey in, one black/white pixel out
//
// Input channel s_*: one grey pixel per item in raster order; s_frame_start
// marks the first pixel of an image and clears all error history, the first
// row of an image diffuses no error from above.
// Result channel m_*: one item per input; m_mono_pixel is 1 for white,
// m_row_end flags the last pixel of each row.
// Config channel cfg_*: cfg_line_width sets pixels per row (0 acts as 1,
// values above MAX_WIDTH act as MAX_WIDTH); cfg_ready is always high and
// writes are meant for idle periods only.
// An accepted item is registered in the s2 stage and then in the result register.
// Throughput: one item per cycle while the result is not stalled; the line store reads the column at accept
// and writes the finished errors when the result register is loaded.
// Stall: while m_ready is low the result and one item in flight are held,
// and s_ready drops once both are full.
// Reset: synchronous, active low; clears the pipeline and the column count
// and sets the line width to 1024. The error carries and the line store are
// not cleared: each row reads only entries written by the row before.
module sierra_lite_bw_dither
    import sbwd_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [LINE_WIDTH_W-1:0] cfg_line_width,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [GREY_W-1:0]       s_grey_level,
    input  logic                    s_frame_start,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_mono_pixel,
    output logic                    m_row_end
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CW = (WW > LINE_WIDTH_W) ? WW : LINE_WIDTH_W;

    logic [LINE_WIDTH_W-1:0] line_width_reg;
    logic [AW-1:0]           col_reg, col_next;
    logic                    first_reg, first_next;

    logic                    s2_valid_reg;
    logic [GREY_W-1:0]       s2_grey_reg;
    logic [AW-1:0]           s2_col_reg;
    logic                    s2_first_reg;
    logic                    s2_last_reg;

    logic signed [HALF_W-1:0]    rc_reg;
    logic signed [QUARTER_W-1:0] bl_reg;

    logic             pend_valid_reg;
    logic [AW-1:0]    pend_addr_reg;
    logic [ERR_W-1:0] pend_data_reg;

    logic m_valid_reg;
    logic m_mono_reg;
    logic m_row_end_reg;

    logic                    accept;
    logic                    fire;
    logic [CW-1:0]           width_eff;
    logic [CW-1:0]           lw_ext;
    logic [AW-1:0]           col_base;
    logic                    first_base;
    logic [AW-1:0]           col_cur;
    logic                    first_cur;
    logic                    last_cur;

    logic [ERR_W-1:0]            store_rd;
    logic signed [ERR_W-1:0]     below_err;
    logic signed [HALF_W-1:0]    right_err;
    logic                        col_zero;
    quant_t                      quant;
    logic [ERR_W-1:0]            merged_err;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [ERR_W-1:0] wr_data;
    logic             pend_valid_next;

    assign cfg_ready = 1'b1;
    assign fire = s2_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s2_valid_reg || fire;
    assign accept = s_valid && s_ready;

    // column bookkeeping, done at accept so the store read can start
    always_comb begin
        lw_ext = CW'(line_width_reg);
        priority if (lw_ext == '0) begin
            width_eff = CW'(1);
        end else if (lw_ext > CW'(MAX_WIDTH)) begin
            width_eff = CW'(MAX_WIDTH);
        end else begin
            width_eff = lw_ext;
        end
        col_base = s_frame_start ? '0 : col_reg;
        first_base = s_frame_start ? 1'b1 : first_reg;
        // width shrunk below the current column ends the previous row
        if (CW'(col_base) >= width_eff) begin
            col_cur = '0;
            first_cur = 1'b0;
        end else begin
            col_cur = col_base;
            first_cur = first_base;
        end
        last_cur = (CW'(col_cur) + CW'(1) >= width_eff);
        col_next = last_cur ? '0 : (col_cur + AW'(1));
        first_next = last_cur ? 1'b0 : first_cur;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg <= LINE_WIDTH_W'(LINE_WIDTH_RST);
            col_reg <= '0;
            first_reg <= 1'b1;
            s2_valid_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                line_width_reg <= cfg_line_width;
            end
            if (accept) begin
                col_reg <= col_next;
                first_reg <= first_next;
            end
            if (accept) begin
                s2_valid_reg <= 1'b1;
            end else if (fire) begin
                s2_valid_reg <= 1'b0;
            end
            pend_valid_reg <= pend_valid_next;
            if (fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s2_grey_reg <= s_grey_level;
            s2_col_reg <= col_cur;
            s2_first_reg <= first_cur;
            s2_last_reg <= last_cur;
        end
        if (fire) begin
            rc_reg <= quant.half;
            bl_reg <= quant.quarter;
            m_mono_reg <= quant.white;
            m_row_end_reg <= s2_last_reg;
        end
        if (pend_valid_next) begin
            pend_addr_reg <= s2_col_reg;
            pend_data_reg <= ERR_W'(quant.quarter);
        end
    end

    sbwd_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (col_cur),
        .rd_data (store_rd),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // carries are only meaningful past the first column of a row
    always_comb begin
        col_zero = (s2_col_reg == '0);
        below_err = s2_first_reg ? '0 : $signed(store_rd);
        right_err = col_zero ? '0 : rc_reg;
    end

    sbwd_quant u_quant (
        .grey_level (s2_grey_reg),
        .below_err  (below_err),
        .right_err  (right_err),
        .result     (quant)
    );

    // one write port: the right-edge write of a row end is held in the pending register and goes out in the next cycle
    always_comb begin
        merged_err = ERR_W'(bl_reg) + ERR_W'(quant.quarter);
        wr_en = 1'b0;
        wr_addr = pend_addr_reg;
        wr_data = pend_data_reg;
        pend_valid_next = fire && !col_zero && s2_last_reg;
        priority if (pend_valid_reg) begin
            wr_en = 1'b1;
        end else if (fire && !col_zero) begin
            wr_en = 1'b1;
            wr_addr = s2_col_reg - AW'(1);
            wr_data = merged_err;
        end else if (fire && s2_last_reg) begin
            wr_en = 1'b1;
            wr_addr = s2_col_reg;
            wr_data = ERR_W'(quant.quarter);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_mono_pixel = m_mono_reg;
    assign m_row_end = m_row_end_reg;

endmodule

>>> rtl/core/sbwd_checker.sv
// port level checks for the ditherer, bound to the top level
module sbwd_checker
    import sbwd_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_mono_pixel,
    input logic m_row_end
);

    // pipeline and result register come out of reset empty
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a free receiver never back-pressures the input
    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while receiver ready");

    // a fresh result always follows an accepted item that passed the s2 stage register
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result without a matching item");

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_mono_pixel) && $stable(m_row_end))
        else $error("stalled result changed");

endmodule

bind sierra_lite_bw_dither sbwd_checker u_sbwd_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_mono_pixel (m_mono_pixel),
    .m_row_end    (m_row_end)
);
